// ===== rtl/pgpg_pkg.sv =====
// Shared types, widths and constants for the polar Gaussian pair generator.
`timescale 1ns / 1ps
`default_nettype none
package pgpg_pkg;
  localparam int UNIFORM_BITS_DEFAULT = 32;
  localparam int U_W = 32;
  localparam int N_W = 32;
  localparam int P_W = 6;
  localparam int K_W = 6;
  localparam int H_W = 5;
  localparam int T_W = 40;
  localparam int Q_W = 60;
  localparam int R_W = 32;
  localparam int C_W = 25;
  localparam int LOG_N = 32;
  localparam int SQRT_N = 32;
  localparam logic [C_W-1:0] TWO_LN2_Q24 = 25'd23258159;

  typedef struct packed {
    logic [U_W-1:0] uniform_first;
    logic [U_W-1:0] uniform_second;
  } in_t;

  typedef struct packed {
    logic signed [N_W-1:0] normal_first;
    logic signed [N_W-1:0] normal_second;
  } out_t;

  typedef struct packed {
    logic [31:0]    mag_first;
    logic [31:0]    mag_second;
    logic           neg_first;
    logic           neg_second;
    logic [H_W-1:0] h;
  } side_t;
endpackage
`default_nettype wire

// ===== rtl/polar_gaussian_pair_generator.sv =====
// Top level: polar-method Gaussian pair generator, fully pipelined.
// Throughput: one uniform pair per cycle while the output is not stalled; rejected pairs leave no result.
// The pipeline holds 32 log2 squaring stages, 60 divider stages and 32 square root stages.
// A one-entry skid register takes one pair while the output is stalled.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module polar_gaussian_pair_generator #(
  parameter int UNIFORM_BITS = pgpg_pkg::UNIFORM_BITS_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     uniform_valid,
  output logic          uniform_ready,
  input  wire pgpg_pkg::in_t uniform,
  output logic          normal_valid,
  input  wire logic     normal_ready,
  output pgpg_pkg::out_t normal
);
  import pgpg_pkg::*;

  localparam int USHIFT = U_W - UNIFORM_BITS;

  function automatic logic [P_W-1:0] lead_one(input logic [63:0] v);
    logic [P_W-1:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = P_W'(i);
    end
    return p;
  endfunction

  function automatic logic [N_W-1:0] scale(input logic [63:0] prod, input logic neg,
                                           input logic [H_W-1:0] h);
    logic [5:0]  sh;
    logic [63:0] x;
    sh = 6'd32 - {1'b0, h};
    x  = (prod + (64'd1 << (sh - 6'd1))) >> sh;
    if (!neg && x > 64'h7FFF_FFFF) x = 64'h7FFF_FFFF;
    if (neg && x > 64'h8000_0000) x = 64'h8000_0000;
    if (neg) x = 64'd0 - x;
    return x[N_W-1:0];
  endfunction

  logic en;
  assign en = !normal_valid || normal_ready;

  // skid
  logic skid_valid;
  in_t  skid;
  in_t  src;
  logic src_valid;
  assign uniform_ready = !skid_valid;
  assign src       = skid_valid ? skid : uniform;
  assign src_valid = skid_valid || uniform_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (uniform_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && !skid_valid && uniform_valid) begin
      skid <= uniform;
    end
  end

  // stage A: map to magnitude and sign of 2u-1
  logic [31:0] uq1, uq2;
  logic [32:0] two1, two2;
  logic        ng1, ng2;
  logic [31:0] mg1, mg2;
  assign uq1  = U_W'(src.uniform_first << USHIFT);
  assign uq2  = U_W'(src.uniform_second << USHIFT);
  assign two1 = {uq1, 1'b0};
  assign two2 = {uq2, 1'b0};
  assign ng1  = ~uq1[31];
  assign ng2  = ~uq2[31];
  assign mg1  = ng1 ? 32'(33'h1_0000_0000 - two1) : two1[31:0];
  assign mg2  = ng2 ? 32'(33'h1_0000_0000 - two2) : two2[31:0];

  logic  va, vb, vc, vd, ve;
  side_t side_a, side_b, side_c, side_d, side_e;
  side_t side_dh;
  logic [63:0] sq1, sq2, sq_b1, sq_b2;
  logic [64:0] sum_c;
  logic [63:0] s_c, s_d, m_e;
  logic [P_W-1:0] p_d, p_e;

  assign sq1   = side_a.mag_first * side_a.mag_first;
  assign sq2   = side_a.mag_second * side_a.mag_second;
  assign sum_c = {1'b0, sq_b1} + {1'b0, sq_b2};

  always_comb begin
    side_dh   = side_d;
    side_dh.h = H_W'((7'd65 - {1'b0, p_d}) >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else if (en) begin
      va <= src_valid && uq1 != '0 && uq2 != '0;
      vb <= va;
      vc <= vb && !sum_c[64] && sum_c[63:0] != '0;
      vd <= vc;
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a.mag_first  <= mg1;
      side_a.mag_second <= mg2;
      side_a.neg_first  <= ng1;
      side_a.neg_second <= ng2;
      side_a.h          <= '0;
      side_b <= side_a;
      sq_b1  <= sq1;
      sq_b2  <= sq2;
      side_c <= side_b;
      s_c    <= sum_c[63:0];
      side_d <= side_c;
      s_d    <= s_c;
      p_d    <= lead_one(s_c);
      side_e <= side_dh;
      m_e    <= s_d << (P_W'(63) - p_d);
      p_e    <= p_d;
    end
  end

  // log2 fraction by repeated squaring
  logic           lv [0:LOG_N];
  logic [31:0]    ly [0:LOG_N];
  logic [31:0]    lf [0:LOG_N];
  logic [K_W-1:0] lk [0:LOG_N];
  logic [31:0]    ld [0:LOG_N];
  side_t          ls [0:LOG_N];

  assign lv[0] = ve;
  assign ly[0] = m_e[63:32];
  assign lf[0] = '0;
  assign lk[0] = K_W'(7'd64 - {1'b0, p_e});
  assign ld[0] = p_e[0] ? m_e[63:32] : {1'b0, m_e[63:33]};
  assign ls[0] = side_e;

  for (genvar i = 0; i < LOG_N; i++) begin : g_log
    logic [63:0] sq;
    assign sq = ly[i] * ly[i];
    always_ff @(posedge clk) begin
      if (rst) begin
        lv[i+1] <= 1'b0;
      end else if (en) begin
        lv[i+1] <= lv[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ly[i+1] <= sq[63] ? sq[63:32] : sq[62:31];
        lf[i+1] <= {lf[i][30:0], sq[63]};
        lk[i+1] <= lk[i];
        ld[i+1] <= ld[i];
        ls[i+1] <= ls[i];
      end
    end
  end

  // t = -2 ln s in Q.32, split into two products
  logic                   vm1, vm2;
  logic [K_W+C_W-1:0]     kc;
  logic [32+C_W-1:0]      fc;
  logic [31:0]            d_m1, d_m2;
  side_t                  side_m1, side_m2;
  logic [63:0]            tsum;
  logic [T_W-1:0]         t_m2;

  assign tsum = 64'({kc, 32'd0}) - 64'(fc) + (64'd1 << 23);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
      vm2 <= 1'b0;
    end else if (en) begin
      vm1 <= lv[LOG_N];
      vm2 <= vm1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kc      <= lk[LOG_N] * TWO_LN2_Q24;
      fc      <= lf[LOG_N] * TWO_LN2_Q24;
      d_m1    <= ld[LOG_N];
      side_m1 <= ls[LOG_N];
      t_m2    <= tsum[T_W+23:24];
      d_m2    <= d_m1;
      side_m2 <= side_m1;
    end
  end

  logic           vdiv;
  logic [Q_W-1:0] q_div;
  side_t          side_div;

  pgpg_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid   (vm2),
    .t       (t_m2),
    .d       (d_m2),
    .side    (side_m2),
    .valid_q (vdiv),
    .q       (q_div),
    .side_q  (side_div)
  );

  logic           vsq;
  logic [R_W-1:0] r_sq;
  side_t          side_sq;

  pgpg_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid   (vdiv),
    .q       (q_div),
    .side    (side_div),
    .valid_r (vsq),
    .r       (r_sq),
    .side_r  (side_sq)
  );

  // scale by magnitudes, round, sign
  logic        vp1;
  logic [63:0] pa, pb;
  side_t       side_p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp1          <= 1'b0;
      normal_valid <= 1'b0;
    end else if (en) begin
      vp1          <= vsq;
      normal_valid <= vp1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa      <= side_sq.mag_first * r_sq;
      pb      <= side_sq.mag_second * r_sq;
      side_p1 <= side_sq;
      normal.normal_first  <= scale(pa, side_p1.neg_first, side_p1.h);
      normal.normal_second <= scale(pb, side_p1.neg_second, side_p1.h);
    end
  end

  a_s_min: assert property (@(posedge clk) disable iff (rst) vd |-> s_d[63:2] != '0)
    else $error("accepted pair with s below 4");
  a_norm: assert property (@(posedge clk) disable iff (rst) ve |-> m_e[63])
    else $error("normalized mantissa lacks top bit");
  a_log: assert property (@(posedge clk) disable iff (rst)
    lv[LOG_N] |-> ly[LOG_N][31] && ld[LOG_N][31:30] != 2'b00)
    else $error("log chain or divisor out of range");
  a_skid: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !en |=> skid_valid && $stable(skid))
    else $error("skid entry lost during stall");
endmodule
`default_nettype wire

// ===== rtl/pgpg_div.sv =====
// Restoring divider pipeline: q = floor(t * 2^50 / d), one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module pgpg_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    valid,
  input  wire logic [pgpg_pkg::T_W-1:0] t,
  input  wire logic [31:0]             d,
  input  wire pgpg_pkg::side_t         side,
  output logic                         valid_q,
  output logic [pgpg_pkg::Q_W-1:0]     q,
  output pgpg_pkg::side_t              side_q
);
  import pgpg_pkg::*;

  localparam int FRAC = 50;

  logic           vld [0:Q_W];
  logic [31:0]    rem [0:Q_W];
  logic [Q_W-1:0] quo [0:Q_W];
  logic [T_W-1:0] tt  [0:Q_W];
  logic [31:0]    dd  [0:Q_W];
  side_t          sd  [0:Q_W];

  assign vld[0] = valid;
  assign rem[0] = 32'(t >> (Q_W - FRAC));
  assign quo[0] = '0;
  assign tt[0]  = t;
  assign dd[0]  = d;
  assign sd[0]  = side;

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    localparam int BI = Q_W - 1 - i;
    logic        nb;
    logic [32:0] sh;
    logic [33:0] trial;
    if (BI >= FRAC) begin : g_bit
      assign nb = tt[i][BI-FRAC];
    end else begin : g_zero
      assign nb = 1'b0;
    end
    assign sh    = {rem[i], nb};
    assign trial = {1'b0, sh} - {2'b00, dd[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= trial[33] ? sh[31:0] : trial[31:0];
        quo[i+1] <= {quo[i][Q_W-2:0], ~trial[33]};
        tt[i+1]  <= tt[i];
        dd[i+1]  <= dd[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign valid_q = vld[Q_W];
  assign q       = quo[Q_W];
  assign side_q  = sd[Q_W];
endmodule
`default_nettype wire

// ===== rtl/pgpg_sqrt.sv =====
// Integer square root pipeline, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module pgpg_sqrt (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    valid,
  input  wire logic [pgpg_pkg::Q_W-1:0] q,
  input  wire pgpg_pkg::side_t         side,
  output logic                         valid_r,
  output logic [pgpg_pkg::R_W-1:0]     r,
  output pgpg_pkg::side_t              side_r
);
  import pgpg_pkg::*;

  logic        vld [0:SQRT_N];
  logic [63:0] x   [0:SQRT_N];
  logic [63:0] res [0:SQRT_N];
  side_t       sd  [0:SQRT_N];

  assign vld[0] = valid;
  assign x[0]   = 64'(q);
  assign res[0] = '0;
  assign sd[0]  = side;

  for (genvar j = 0; j < SQRT_N; j++) begin : g_step
    localparam logic [63:0] B = 64'd1 << (62 - 2 * j);
    logic [63:0] rb;
    logic        take;
    assign rb   = res[j] + B;
    assign take = x[j] >= rb;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x[j+1]   <= take ? x[j] - rb : x[j];
        res[j+1] <= take ? (res[j] >> 1) + B : res[j] >> 1;
        sd[j+1]  <= sd[j];
      end
    end
  end

  assign valid_r = vld[SQRT_N];
  assign r       = res[SQRT_N][R_W-1:0];
  assign side_r  = sd[SQRT_N];
endmodule
`default_nettype wire
